[src/salwbc_pkg.sv]
`timescale 1ns / 1ps

package salwbc_pkg;

    // Cache geometry. BLOCK_BYTES and SETS are powers of two, so the offset
    // and set fields are plain bit fields of the address.
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 8;
    localparam int SETS        = 8;

    localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_BITS    = 32 - OFFSET_BITS;
    localparam int WAYS_POW2   = 1 << WAY_BITS;

    typedef struct packed {
        logic        cmd;
        logic [31:0] address;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic        dirty_evict;
        logic [31:0] victim_block_address;
        logic [1:0]  way_used;
    } rsp_t;

    // One way of a set as kept in the tag memory.
    typedef struct packed {
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         stamp;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    localparam int ROW_BITS = $bits(row_t);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
    } dp_cmd_t;

    function automatic logic [SET_BITS-1:0] set_of(input logic [31:0] addr);
        logic [31:0] sel;
        sel = (addr >> OFFSET_BITS) & 32'(SETS - 1);
        return sel[SET_BITS-1:0];
    endfunction

endpackage

[src/set_assoc_lru_writeback_cache.sv]
`timescale 1ns / 1ps

// Tag side of a set-associative, write-back, write-allocate cache with
// least-recently-used replacement.
//
// Request channel: req carries the access (cmd 0 read, 1 write) and its byte
// address. A transfer happens at the rising edge where start is high and busy
// is low. busy rises for one cycle after each transfer.
// Response channel: rsp holds hit, dirty_evict, the victim block address and
// the way used. It is valid for exactly one cycle, marked by done; the
// receiver cannot stall, so each response must be taken when it appears.
// The set's row is read from the tag memory at the transfer edge. At the end
// of the lookup state that follows, it is written back, updated, and done
// rises together with the registered response. No access is taken while busy.
// Back-to-back accesses to the same set see each other's updates.
// Reset clears every valid bit and the access counter at once, so the block
// accepts its first access in the first cycle after reset is released.
module set_assoc_lru_writeback_cache (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  salwbc_pkg::req_t req,
    output logic             done,
    output salwbc_pkg::rsp_t rsp
);

    salwbc_pkg::dp_cmd_t dp_cmd;

    salwbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (dp_cmd)
    );

    salwbc_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (dp_cmd),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef ASSERT_OFF
    a_lookup_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted access");

    a_response_follows_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("no response one cycle after lookup");

    a_done_only_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("response strobe without a lookup");

    a_writeback_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.dirty_evict |-> !rsp.hit)
        else $error("write-back flagged on a hit");

    a_no_victim_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.hit |-> rsp.victim_block_address == 32'd0)
        else $error("victim address reported on a hit");
`endif

endmodule

[src/salwbc_ram.sv]
`timescale 1ns / 1ps

module salwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/salwbc_ctrl.sv]
`timescale 1ns / 1ps

module salwbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output salwbc_pkg::dp_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg <= ST_LOOKUP;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_LOOKUP:
                begin
                    // The set row is written back at the end of this cycle.
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign cmd.capture = accept;
    assign cmd.update  = (state_reg == ST_LOOKUP);

endmodule

[src/salwbc_dp.sv]
`timescale 1ns / 1ps

module salwbc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  salwbc_pkg::dp_cmd_t cmd,
    input  salwbc_pkg::req_t    req,
    output salwbc_pkg::rsp_t    rsp
);

    localparam int WAYS      = salwbc_pkg::WAYS;
    localparam int WAY_BITS  = salwbc_pkg::WAY_BITS;
    localparam int WAYS_POW2 = salwbc_pkg::WAYS_POW2;
    localparam int TAG_BITS  = salwbc_pkg::TAG_BITS;
    localparam int SET_BITS  = salwbc_pkg::SET_BITS;

    logic [salwbc_pkg::SETS-1:0][WAYS-1:0] valid_reg;
    logic [31:0]                           counter_reg;
    logic                                  cmd_reg;
    logic [31:0]                           addr_reg;
    salwbc_pkg::rsp_t                      rsp_reg;

    logic [salwbc_pkg::ROW_BITS-1:0] ram_rdata;
    salwbc_pkg::row_t                rd_row;
    salwbc_pkg::row_t                wr_row;
    logic [SET_BITS-1:0]             set_idx;
    logic [TAG_BITS-1:0]             tag_in;
    logic [WAYS-1:0]                 vrow;

    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                has_empty;
    logic [WAY_BITS-1:0] empty_way;
    logic [WAY_BITS-1:0] victim_way;
    logic [WAY_BITS-1:0] use_way;
    logic                evict;
    salwbc_pkg::entry_t  victim_entry;
    salwbc_pkg::entry_t  new_entry;
    salwbc_pkg::rsp_t    rsp_next;

    logic [31:0]         cand_stamp [WAYS_POW2];
    logic [WAY_BITS-1:0] cand_way   [WAYS_POW2];

    assign set_idx = salwbc_pkg::set_of(addr_reg);
    assign tag_in  = addr_reg[31:salwbc_pkg::OFFSET_BITS];
    assign vrow    = valid_reg[set_idx];
    assign rd_row  = ram_rdata;

    salwbc_ram #(
        .WIDTH (salwbc_pkg::ROW_BITS),
        .DEPTH (salwbc_pkg::SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (set_idx),
        .wdata (wr_row),
        .re    (cmd.capture),
        .raddr (salwbc_pkg::set_of(req.address)),
        .rdata (ram_rdata)
    );

    // Lowest matching way and lowest empty way.
    always_comb
    begin
        hit       = 1'b0;
        hit_way   = '0;
        has_empty = 1'b0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vrow[w] && rd_row[w].tag == tag_in)
            begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!vrow[w])
            begin
                has_empty = 1'b1;
                empty_way = WAY_BITS'(w);
            end
        end
    end

    // Oldest stamp through a pairwise tree; the left side wins a tie, so the
    // lowest way among equal stamps is chosen. Padding never wins.
    always_comb
    begin
        for (int i = 0; i < WAYS_POW2; i++)
        begin
            if (i < WAYS)
            begin
                cand_stamp[i] = rd_row[i].stamp;
            end
            else
            begin
                cand_stamp[i] = '1;
            end
            cand_way[i] = WAY_BITS'(i);
        end
        for (int s = WAYS_POW2 / 2; s >= 1; s = s >> 1)
        begin
            for (int i = 0; i < s; i++)
            begin
                if (cand_stamp[2*i+1] < cand_stamp[2*i])
                begin
                    cand_stamp[i] = cand_stamp[2*i+1];
                    cand_way[i]   = cand_way[2*i+1];
                end
                else
                begin
                    cand_stamp[i] = cand_stamp[2*i];
                    cand_way[i]   = cand_way[2*i];
                end
            end
        end
        victim_way = cand_way[0];
    end

    always_comb
    begin
        evict        = !hit && !has_empty;
        victim_entry = rd_row[victim_way];
        if (hit)
        begin
            use_way = hit_way;
        end
        else if (has_empty)
        begin
            use_way = empty_way;
        end
        else
        begin
            use_way = victim_way;
        end

        new_entry       = rd_row[use_way];
        new_entry.stamp = counter_reg;
        if (hit)
        begin
            new_entry.dirty = rd_row[use_way].dirty | cmd_reg;
        end
        else
        begin
            new_entry.dirty = cmd_reg;
            new_entry.tag   = tag_in;
        end

        wr_row          = rd_row;
        wr_row[use_way] = new_entry;

        rsp_next.hit         = hit;
        rsp_next.dirty_evict = evict && victim_entry.dirty;
        if (evict)
        begin
            rsp_next.victim_block_address =
                {victim_entry.tag, {salwbc_pkg::OFFSET_BITS{1'b0}}};
        end
        else
        begin
            rsp_next.victim_block_address = '0;
        end
        rsp_next.way_used = 2'(use_way);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            counter_reg <= '0;
        end
        else if (cmd.update)
        begin
            valid_reg[set_idx][use_way] <= 1'b1;
            counter_reg                 <= counter_reg + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= req.cmd;
            addr_reg <= req.address;
        end
        if (cmd.update)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

[tb/set_assoc_lru_writeback_cache_checker.sv]
`timescale 1ns / 1ps

module set_assoc_lru_writeback_cache_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  salwbc_pkg::req_t req,
    input  logic             done,
    input  salwbc_pkg::rsp_t rsp,
    output int               mismatches,
    output int               outstanding
);

    localparam int WAYS        = salwbc_pkg::WAYS;
    localparam int SETS        = salwbc_pkg::SETS;
    localparam int BLOCK_BYTES = salwbc_pkg::BLOCK_BYTES;
    localparam int ENTRIES     = SETS * WAYS;

    bit [31:0] line_addr [ENTRIES];
    bit        line_valid [ENTRIES];
    bit        line_dirty [ENTRIES];
    bit [31:0] line_stamp [ENTRIES];
    bit [31:0] stamp_counter;

    salwbc_pkg::rsp_t lookup_results [$];

    // Looks the access up in the shadow tag store, updates it, and returns the
    // response the block should give.
    function automatic salwbc_pkg::rsp_t lookup_and_update(input salwbc_pkg::req_t r);
        salwbc_pkg::rsp_t res;
        bit [31:0]        blk;
        bit [31:0]        stamp;
        int               base;
        int               hit_way;
        int               victim;
        bit               has_empty;
        blk       = r.address - (r.address % 32'(BLOCK_BYTES));
        base      = int'((r.address / 32'(BLOCK_BYTES)) % 32'(SETS)) * WAYS;
        stamp     = stamp_counter;
        stamp_counter = stamp_counter + 32'd1;
        res       = '0;
        hit_way   = -1;
        has_empty = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (line_valid[base + w] && line_addr[base + w] == blk)
            begin
                hit_way = w;
                break;
            end
            if (!line_valid[base + w])
                has_empty = 1'b1;
        end
        if (hit_way >= 0)
        begin
            res.hit = 1'b1;
            res.way_used = 2'(hit_way);
            line_stamp[base + hit_way] = stamp;
            if (r.cmd)
                line_dirty[base + hit_way] = 1'b1;
        end
        else
        begin
            if (!has_empty)
            begin
                // Oldest stamp loses; among equal stamps the lowest way loses.
                victim = 0;
                for (int w = 1; w < WAYS; w++)
                begin
                    if (line_stamp[base + w] < line_stamp[base + victim])
                        victim = w;
                end
                res.victim_block_address = line_addr[base + victim];
                res.dirty_evict = line_dirty[base + victim];
                line_valid[base + victim] = 1'b0;
                line_dirty[base + victim] = 1'b0;
                line_addr[base + victim]  = '0;
                line_stamp[base + victim] = '0;
            end
            for (int w = 0; w < WAYS; w++)
            begin
                if (!line_valid[base + w])
                begin
                    line_addr[base + w]  = blk;
                    line_valid[base + w] = 1'b1;
                    line_dirty[base + w] = r.cmd;
                    line_stamp[base + w] = stamp;
                    res.way_used = 2'(w);
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic report_failure(input string what, input salwbc_pkg::rsp_t want,
                                  input salwbc_pkg::rsp_t got);
        if (mismatches < 10)
            $display({"%0t: %s: expected hit=%0b wb=%0b victim=%08h way=%0d, ",
                      "got hit=%0b wb=%0b victim=%08h way=%0d"},
                     $realtime, what, want.hit, want.dirty_evict,
                     want.victim_block_address, want.way_used, got.hit,
                     got.dirty_evict, got.victim_block_address, got.way_used);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        salwbc_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                line_addr[i]  = '0;
                line_valid[i] = 1'b0;
                line_dirty[i] = 1'b0;
                line_stamp[i] = '0;
            end
            stamp_counter = '0;
            lookup_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // Responses are checked before this edge's transfer is predicted, so
            // a response and a new access on the same edge keep their order.
            if (done === 1'b1)
            begin
                if (lookup_results.size() == 0)
                begin
                    report_failure("response with none outstanding", '0, rsp);
                end
                else
                begin
                    want = lookup_results.pop_front();
                    if (rsp.hit !== want.hit || rsp.dirty_evict !== want.dirty_evict ||
                        rsp.victim_block_address !== want.victim_block_address ||
                        rsp.way_used !== want.way_used)
                        report_failure("response mismatch", want, rsp);
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                lookup_results.push_back(lookup_and_update(req));
            outstanding = lookup_results.size();
        end
    end

endmodule

[tb/set_assoc_lru_writeback_cache_tb.sv]
`timescale 1ns / 1ps

module set_assoc_lru_writeback_cache_tb;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;
    localparam int   RANDOM_ACCESSES = 1500;
    localparam int   QUIET_TAIL = 200;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             done;
    salwbc_pkg::req_t req;
    salwbc_pkg::rsp_t rsp;
    int               mismatches;
    int               outstanding;

    set_assoc_lru_writeback_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    set_assoc_lru_writeback_cache_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic access(input logic cmd, input logic [31:0] addr, input bit may_pause);
        if (may_pause && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        start <= 1'b1;
        req   <= '{cmd: cmd, address: addr};
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] region;
        logic [31:0] addr;
        int          pick;
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill and hit, then a dirty eviction whose victim is block zero.
        access(CMD_READ,  32'h0000_0000, 1'b0);
        access(CMD_WRITE, 32'h0000_0000, 1'b0);
        access(CMD_READ,  32'h0000_0007, 1'b0);
        access(CMD_READ,  32'h0000_0040, 1'b0);
        access(CMD_READ,  32'h0000_0080, 1'b0);
        access(CMD_READ,  32'h0000_00C0, 1'b0);
        access(CMD_WRITE, 32'h0000_0100, 1'b0);
        // Clean eviction of the next oldest block.
        access(CMD_READ,  32'h0000_0140, 1'b0);
        // Top of the address space.
        access(CMD_WRITE, 32'hFFFF_FFFF, 1'b0);
        access(CMD_READ,  32'hFFFF_FFF8, 1'b0);
        // A hit refreshes the stamp, so the second way becomes the victim.
        access(CMD_READ,  32'h0000_0008, 1'b0);
        access(CMD_WRITE, 32'h0000_0048, 1'b0);
        access(CMD_READ,  32'h0000_0088, 1'b0);
        access(CMD_READ,  32'h0000_00C8, 1'b0);
        access(CMD_READ,  32'h0000_000C, 1'b0);
        access(CMD_READ,  32'h8000_0008, 1'b0);
        access(CMD_WRITE, 32'h8000_0008, 1'b0);
        access(CMD_READ,  32'h5555_5550, 1'b0);
        access(CMD_WRITE, 32'hAAAA_AAAA, 1'b0);

        region = $urandom & 32'hFFFF_F000;
        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            if ($urandom_range(0, 99) == 0)
                region = $urandom & 32'hFFFF_F000;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                // Six blocks compete for the four ways of each set.
                addr = region + ($urandom_range(0, 5) << 6) + ($urandom_range(0, 7) << 3)
                       + $urandom_range(0, 7);
            else if (pick < 9)
                addr = $urandom;
            else
                addr = 32'hFFFF_FFFF - $urandom_range(0, 127);
            access(1'($urandom_range(0, 1)), addr, n < RANDOM_ACCESSES - QUIET_TAIL);
        end
        start <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
src/salwbc_pkg.sv
src/salwbc_ram.sv
src/salwbc_ctrl.sv
src/salwbc_dp.sv
src/set_assoc_lru_writeback_cache.sv
tb/set_assoc_lru_writeback_cache_checker.sv
tb/set_assoc_lru_writeback_cache_tb.sv
